// File: src/lav_pkg.sv
// Package: shared constants, context type and rounding and saturation helpers for the look-at unit.
package lav_pkg;

	localparam int Q_FRAC   = 16;
	localparam int ONE      = 65536;
	localparam int NW       = 18;
	localparam int SQ_STG   = 32;
	localparam int DIV_STG  = Q_FRAC + 1;
	localparam logic [7:0]  SHORT_SQ = 8'd43;
	localparam logic [31:0] M_HI = 32'h8000_0000;
	localparam logic [31:0] M_LO = 32'h4000_0000;

	typedef struct packed {
		logic [2:0][31:0]   m;
		logic [2:0]         neg;
		logic [2:0][NW-1:0] pv;
		logic               shrt;
	} lav_ctx_t;

	// Q32.32 to Q16.16, nearest, ties away from zero
	function automatic logic signed [63:0] rnd16(input logic signed [63:0] x);
		logic [63:0] m;
		logic [63:0] r;
		m = x[63] ? 64'(-x) : 64'(x);
		r = (m + 64'h8000) >> Q_FRAC;
		return x[63] ? -$signed(r) : $signed(r);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		if (x > 64'sh7FFF_FFFF)
			return 32'sh7FFF_FFFF;
		else if (x < -64'sh8000_0000)
			return -32'sh8000_0000;
		else
			return 32'(x);
	endfunction

endpackage

// File: src/lav_norm.sv
// Pipelined vector normalizer: block shift, sum of squares, square root, divide.
module lav_norm #(
	parameter int W  = 33,
	parameter int DW = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_vld,
	input  logic [2:0][W-1:0]                 v,
	input  logic [DW-1:0]                     in_data,
	output logic                              out_vld,
	output logic [2:0][lav_pkg::NW-1:0]       u,
	output logic [DW-1:0]                     out_data
);
	import lav_pkg::*;

	localparam int PW  = $clog2(W);
	localparam int LAT = 6 + SQ_STG + 1 + DIV_STG + 1;

	function automatic logic [PW-1:0] top_bit(input logic [W-1:0] x);
		logic [PW-1:0] p;
		p = '0;
		for (int i = 0; i < W; i++)
			if (x[i])
				p = PW'(i);
		return p;
	endfunction

	logic [LAT:1]  vld_s;
	logic [DW-1:0] pay_s [1:LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s <= '0;
		else
			vld_s <= {vld_s[LAT-1:1], in_vld};
	end

	always_ff @(posedge clk) begin
		pay_s[1] <= in_data;
		for (int i = 2; i <= LAT; i++)
			pay_s[i] <= pay_s[i-1];
	end

	// stage 1: magnitudes and max
	logic [2:0][W-1:0]  mag;
	logic [W-1:0]       mx;
	logic [2:0][W-1:0]  m_s1;
	logic [W-1:0]       mx_s1;
	logic [2:0]         neg_s1;
	logic [2:0][NW-1:0] pv_s1;
	logic               small_s1;

	always_comb begin
		mx = '0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = v[i][W-1] ? W'(-$signed(v[i])) : v[i];
			if (mag[i] > mx)
				mx = mag[i];
		end
	end

	always_ff @(posedge clk) begin
		m_s1     <= mag;
		mx_s1    <= mx;
		small_s1 <= mx < W'(8);
		for (int i = 0; i < 3; i++) begin
			neg_s1[i] <= v[i][W-1];
			pv_s1[i]  <= v[i][NW-1:0];
		end
	end

	// stage 2: leading bit, short test
	logic [7:0]         ss;
	logic [2:0][W-1:0]  m_s2;
	logic [W-1:0]       mx_s2;
	logic [PW-1:0]      p_s2;
	logic [2:0]         neg_s2;
	logic [2:0][NW-1:0] pv_s2;
	logic               shrt_s2;

	always_comb begin
		ss = '0;
		for (int i = 0; i < 3; i++)
			ss = ss + 8'(m_s1[i][2:0]) * 8'(m_s1[i][2:0]);
	end

	always_ff @(posedge clk) begin
		m_s2    <= m_s1;
		mx_s2   <= mx_s1;
		p_s2    <= top_bit(mx_s1);
		neg_s2  <= neg_s1;
		pv_s2   <= pv_s1;
		shrt_s2 <= small_s1 && (ss < SHORT_SQ);
	end

	// stage 3: coarse block shift
	logic [PW-1:0]      ra;
	logic [4:0]         la;
	logic [2:0][31:0]   ms;
	logic [31:0]        mxs;
	logic [2:0][31:0]   m_s3;
	logic [31:0]        mx_s3;
	logic [2:0]         neg_s3;
	logic [2:0][NW-1:0] pv_s3;
	logic               shrt_s3;

	always_comb begin
		ra = '0;
		la = '0;
		if (p_s2 > PW'(30)) begin
			ra  = PW'(p_s2 - PW'(31));
			mxs = 32'(mx_s2 >> ra);
			for (int i = 0; i < 3; i++)
				ms[i] = 32'(m_s2[i] >> ra);
		end else begin
			la  = 5'(PW'(30) - p_s2);
			mxs = mx_s2[31:0] << la;
			for (int i = 0; i < 3; i++)
				ms[i] = m_s2[i][31:0] << la;
		end
	end

	always_ff @(posedge clk) begin
		m_s3    <= ms;
		mx_s3   <= mxs;
		neg_s3  <= neg_s2;
		pv_s3   <= pv_s2;
		shrt_s3 <= shrt_s2;
	end

	// stage 4: final one-bit trim so the max lies in [2^30, 2^31]
	lav_ctx_t ctx_s4;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++)
			ctx_s4.m[i] <= (mx_s3 > M_HI) ? (m_s3[i] >> 1) : m_s3[i];
		ctx_s4.neg  <= neg_s3;
		ctx_s4.pv   <= pv_s3;
		ctx_s4.shrt <= shrt_s3;
	end

	// stage 5: squares
	logic [2:0][63:0] pr_s5;
	lav_ctx_t         ctx_s5;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++)
			pr_s5[i] <= 64'(ctx_s4.m[i]) * 64'(ctx_s4.m[i]);
		ctx_s5 <= ctx_s4;
	end

	// stage 6: sum of squares; stages 7 .. 38: square root, one result bit per stage
	logic [63:0] sx_s [0:SQ_STG];
	logic [63:0] sr_s [0:SQ_STG];
	lav_ctx_t    sc_s [0:SQ_STG];

	always_ff @(posedge clk) begin
		sx_s[0] <= pr_s5[0] + pr_s5[1] + pr_s5[2];
		sr_s[0] <= '0;
		sc_s[0] <= ctx_s5;
	end

	for (genvar k = 0; k < SQ_STG; k++) begin : g_sqrt
		localparam logic [63:0] B = 64'd1 << (2 * (SQ_STG - 1 - k));
		logic [63:0] t;
		assign t = sr_s[k] + B;
		always_ff @(posedge clk) begin
			if (sx_s[k] >= t) begin
				sx_s[k+1] <= sx_s[k] - t;
				sr_s[k+1] <= (sr_s[k] >> 1) + B;
			end else begin
				sx_s[k+1] <= sx_s[k];
				sr_s[k+1] <= sr_s[k] >> 1;
			end
			sc_s[k+1] <= sc_s[k];
		end
	end

	// divider: q = (2*m*2^16 + r) / (2*r), one quotient bit per stage
	logic [32:0]            dd_s [0:DIV_STG];
	logic [2:0][32:0]       dr_s [0:DIV_STG];
	logic [2:0][DIV_STG-1:0] dl_s [0:DIV_STG];
	logic [2:0][DIV_STG-1:0] dq_s [0:DIV_STG];
	lav_ctx_t               dc_s [0:DIV_STG];
	logic [31:0]            rt;
	logic [2:0][48:0]       dsum;

	assign rt = sr_s[SQ_STG][31:0];

	always_comb begin
		for (int i = 0; i < 3; i++)
			dsum[i] = {sc_s[SQ_STG].m[i], 17'd0} + 49'(rt);
	end

	always_ff @(posedge clk) begin
		dd_s[0] <= {rt, 1'b0};
		for (int i = 0; i < 3; i++) begin
			dr_s[0][i] <= {1'b0, dsum[i][48:17]};
			dl_s[0][i] <= dsum[i][16:0];
		end
		dq_s[0] <= '0;
		dc_s[0] <= sc_s[SQ_STG];
	end

	for (genvar j = 0; j < DIV_STG; j++) begin : g_div
		logic [2:0][33:0] t;
		logic [2:0]       ge;
		always_comb begin
			for (int i = 0; i < 3; i++) begin
				t[i]  = {dr_s[j][i], dl_s[j][i][DIV_STG-1]};
				ge[i] = t[i] >= {1'b0, dd_s[j]};
			end
		end
		always_ff @(posedge clk) begin
			for (int i = 0; i < 3; i++) begin
				dr_s[j+1][i] <= ge[i] ? 33'(t[i] - {1'b0, dd_s[j]}) : t[i][32:0];
				dl_s[j+1][i] <= dl_s[j][i] << 1;
				dq_s[j+1][i] <= {dq_s[j][i][DIV_STG-2:0], ge[i]};
			end
			dd_s[j+1] <= dd_s[j];
			dc_s[j+1] <= dc_s[j];
		end
	end

	// output stage: sign, short pass-through
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (dc_s[DIV_STG].shrt)
				u[i] <= dc_s[DIV_STG].pv[i];
			else if (dc_s[DIV_STG].neg[i])
				u[i] <= NW'(-$signed(NW'(dq_s[DIV_STG][i])));
			else
				u[i] <= NW'(dq_s[DIV_STG][i]);
		end
	end

	assign out_vld  = vld_s[LAT];
	assign out_data = pay_s[LAT];

	a_block_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[4] && !ctx_s4.shrt |->
			ctx_s4.m[0] <= M_HI && ctx_s4.m[1] <= M_HI && ctx_s4.m[2] <= M_HI &&
			(ctx_s4.m[0] >= M_LO || ctx_s4.m[1] >= M_LO || ctx_s4.m[2] >= M_LO))
		else $error("normalizer block shift out of range");

	a_quot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[LAT-1] && !dc_s[DIV_STG].shrt |->
			dq_s[DIV_STG][0] <= ONE && dq_s[DIV_STG][1] <= ONE &&
			dq_s[DIV_STG][2] <= ONE)
		else $error("normalizer quotient above one");

	a_out_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld |->
			$signed(u[0]) <= ONE && $signed(u[0]) >= -ONE &&
			$signed(u[1]) <= ONE && $signed(u[1]) >= -ONE &&
			$signed(u[2]) <= ONE && $signed(u[2]) >= -ONE)
		else $error("normalized component out of range");

endmodule

// File: src/look_at_view_matrix.sv
// Top level: look-at view matrix pipeline in signed Q16.16.
// One camera set-up is taken on every cycle that start is high; busy is
// always low. Each transaction returns its twelve matrix entries on the
// result ports with done high for one cycle. Most of the pipeline lies
// in the two normalizers (forward, then side), each a 57-stage pipeline
// holding a 32-stage square root and a 17-stage divider. Results cannot
// be held off, so there is no stall path.
module look_at_view_matrix (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] eye_x,
	input  logic signed [31:0] eye_y,
	input  logic signed [31:0] eye_z,
	input  logic signed [31:0] target_x,
	input  logic signed [31:0] target_y,
	input  logic signed [31:0] target_z,
	input  logic signed [31:0] hint_up_x,
	input  logic signed [31:0] hint_up_y,
	input  logic signed [31:0] hint_up_z,
	output logic               busy,
	output logic               done,
	output logic signed [31:0] side_x,
	output logic signed [31:0] side_y,
	output logic signed [31:0] side_z,
	output logic signed [31:0] true_up_x,
	output logic signed [31:0] true_up_y,
	output logic signed [31:0] true_up_z,
	output logic signed [31:0] back_x,
	output logic signed [31:0] back_y,
	output logic signed [31:0] back_z,
	output logic signed [31:0] shift_x,
	output logic signed [31:0] shift_y,
	output logic signed [31:0] shift_z
);
	import lav_pkg::*;

	assign busy = 1'b0;

	// stage 1: forward = target - eye
	logic             vld_s1;
	logic [2:0][31:0] eye_s1;
	logic [2:0][31:0] hint_s1;
	logic [2:0][32:0] fw_s1;

	always_ff @(posedge clk) begin
		eye_s1   <= {eye_z, eye_y, eye_x};
		hint_s1  <= {hint_up_z, hint_up_y, hint_up_x};
		fw_s1[0] <= 33'(target_x) - 33'(eye_x);
		fw_s1[1] <= 33'(target_y) - 33'(eye_y);
		fw_s1[2] <= 33'(target_z) - 33'(eye_z);
	end

	logic             fa_vld;
	logic [2:0][NW-1:0] fn_a;
	logic [191:0]     da;

	lav_norm #(.W(33), .DW(192)) u_norm_fwd (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s1),
		.v        (fw_s1),
		.in_data  ({hint_s1, eye_s1}),
		.out_vld  (fa_vld),
		.u        (fn_a),
		.out_data (da)
	);

	logic [2:0][31:0] eye_a;
	logic [2:0][31:0] hint_a;
	logic signed [NW-1:0] fa [3];
	logic signed [31:0]   ha [3];

	assign eye_a  = da[95:0];
	assign hint_a = da[191:96];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			fa[i] = $signed(fn_a[i]);
			ha[i] = $signed(hint_a[i]);
		end
	end

	// stage 2: side = forward x hint, products
	logic               vld_s2;
	logic signed [49:0] cp_s2 [6];
	logic [2:0][31:0]   eye_s2;
	logic [2:0][NW-1:0] fn_s2;

	always_ff @(posedge clk) begin
		cp_s2[0] <= fa[1] * ha[2];
		cp_s2[1] <= fa[2] * ha[1];
		cp_s2[2] <= fa[2] * ha[0];
		cp_s2[3] <= fa[0] * ha[2];
		cp_s2[4] <= fa[0] * ha[1];
		cp_s2[5] <= fa[1] * ha[0];
		eye_s2   <= eye_a;
		fn_s2    <= fn_a;
	end

	// stage 3: side differences, rounded
	logic               vld_s3;
	logic [2:0][35:0]   side_raw_s3;
	logic [2:0][31:0]   eye_s3;
	logic [2:0][NW-1:0] fn_s3;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++)
			side_raw_s3[i] <= 36'(rnd16(64'(cp_s2[2*i] - cp_s2[2*i+1])));
		eye_s3 <= eye_s2;
		fn_s3  <= fn_s2;
	end

	logic               sb_vld;
	logic [2:0][NW-1:0] sn_b;
	logic [149:0]       db;

	lav_norm #(.W(36), .DW(150)) u_norm_side (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s3),
		.v        (side_raw_s3),
		.in_data  ({fn_s3, eye_s3}),
		.out_vld  (sb_vld),
		.u        (sn_b),
		.out_data (db)
	);

	logic [2:0][31:0]   eye_b;
	logic [2:0][NW-1:0] fn_b;
	logic signed [NW-1:0] sb [3];
	logic signed [NW-1:0] fb [3];
	logic signed [31:0]   eb [3];

	assign eye_b = db[95:0];
	assign fn_b  = db[149:96];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sb[i] = $signed(sn_b[i]);
			fb[i] = $signed(fn_b[i]);
			eb[i] = $signed(eye_b[i]);
		end
	end

	// stage 4: true up products, side.eye and forward.eye products
	logic               vld_s4;
	logic signed [35:0] upp_s4 [6];
	logic signed [49:0] se_s4 [3];
	logic signed [49:0] fe_s4 [3];
	logic signed [NW-1:0] sn_s4 [3];
	logic signed [NW-1:0] fn_s4 [3];
	logic signed [31:0]   eye_s4 [3];

	always_ff @(posedge clk) begin
		upp_s4[0] <= sb[1] * fb[2];
		upp_s4[1] <= sb[2] * fb[1];
		upp_s4[2] <= sb[2] * fb[0];
		upp_s4[3] <= sb[0] * fb[2];
		upp_s4[4] <= sb[0] * fb[1];
		upp_s4[5] <= sb[1] * fb[0];
		for (int i = 0; i < 3; i++) begin
			se_s4[i]  <= sb[i] * eb[i];
			fe_s4[i]  <= fb[i] * eb[i];
			sn_s4[i]  <= sb[i];
			fn_s4[i]  <= fb[i];
			eye_s4[i] <= eb[i];
		end
	end

	// stage 5: true up, two dot products
	logic               vld_s5;
	logic signed [19:0] up_s5 [3];
	logic signed [39:0] dots_s5;
	logic signed [39:0] dotf_s5;
	logic signed [NW-1:0] sn_s5 [3];
	logic signed [NW-1:0] fn_s5 [3];
	logic signed [31:0]   eye_s5 [3];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			up_s5[i]  <= 20'(rnd16(64'(upp_s4[2*i] - upp_s4[2*i+1])));
			sn_s5[i]  <= sn_s4[i];
			fn_s5[i]  <= fn_s4[i];
			eye_s5[i] <= eye_s4[i];
		end
		dots_s5 <= 40'(rnd16(64'(se_s4[0]) + 64'(se_s4[1]) + 64'(se_s4[2])));
		dotf_s5 <= 40'(rnd16(64'(fe_s4[0]) + 64'(fe_s4[1]) + 64'(fe_s4[2])));
	end

	// stage 6: true up . eye products
	logic               vld_s6;
	logic signed [51:0] ue_s6 [3];
	logic signed [19:0] up_s6 [3];
	logic signed [39:0] dots_s6;
	logic signed [39:0] dotf_s6;
	logic signed [NW-1:0] sn_s6 [3];
	logic signed [NW-1:0] fn_s6 [3];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			ue_s6[i] <= up_s5[i] * eye_s5[i];
			up_s6[i] <= up_s5[i];
			sn_s6[i] <= sn_s5[i];
			fn_s6[i] <= fn_s5[i];
		end
		dots_s6 <= dots_s5;
		dotf_s6 <= dotf_s5;
	end

	// stage 7: output register
	logic signed [63:0] dotu;

	assign dotu = rnd16(64'(ue_s6[0]) + 64'(ue_s6[1]) + 64'(ue_s6[2]));

	always_ff @(posedge clk) begin
		side_x    <= 32'(sn_s6[0]);
		side_y    <= 32'(sn_s6[1]);
		side_z    <= 32'(sn_s6[2]);
		true_up_x <= 32'(up_s6[0]);
		true_up_y <= 32'(up_s6[1]);
		true_up_z <= 32'(up_s6[2]);
		back_x    <= -32'(fn_s6[0]);
		back_y    <= -32'(fn_s6[1]);
		back_z    <= -32'(fn_s6[2]);
		shift_x   <= sat32(-64'(dots_s6));
		shift_y   <= sat32(-dotu);
		shift_z   <= sat32(64'(dotf_s6));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			done   <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= fa_vld;
			vld_s3 <= vld_s2;
			vld_s4 <= sb_vld;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			done   <= vld_s6;
		end
	end

	a_back_unit: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> back_x <= ONE && back_x >= -ONE && back_y <= ONE && back_y >= -ONE &&
			back_z <= ONE && back_z >= -ONE)
		else $error("back vector out of unit range");

	a_side_unit: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> side_x <= ONE && side_x >= -ONE && side_y <= ONE && side_y >= -ONE &&
			side_z <= ONE && side_z >= -ONE)
		else $error("side vector out of unit range");

	a_up_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> true_up_x <= 2 * ONE && true_up_x >= -2 * ONE &&
			true_up_y <= 2 * ONE && true_up_y >= -2 * ONE &&
			true_up_z <= 2 * ONE && true_up_z >= -2 * ONE)
		else $error("true up vector out of range");

endmodule

// File: tb/look_at_view_matrix_tb.sv
// Testbench for the look-at view matrix unit: directed and random set-ups against a predictor.
module look_at_view_matrix_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic [11:0][31:0] view_t;

	localparam int WATCH_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 150;

	logic clk;
	logic arst_n;
	logic start;
	logic signed [31:0] eye_x, eye_y, eye_z;
	logic signed [31:0] target_x, target_y, target_z;
	logic signed [31:0] hint_up_x, hint_up_y, hint_up_z;
	logic busy, done;
	logic signed [31:0] side_x, side_y, side_z;
	logic signed [31:0] true_up_x, true_up_y, true_up_z;
	logic signed [31:0] back_x, back_y, back_z;
	logic signed [31:0] shift_x, shift_y, shift_z;

	view_t pending_views[$];
	int errors = 0;
	int quiet_cycles = 0;
	int sender_idle_pct = 0;
	string entry_name [12] = '{"side_x", "side_y", "side_z", "true_up_x", "true_up_y",
		"true_up_z", "back_x", "back_y", "back_z", "shift_x", "shift_y", "shift_z"};

	look_at_view_matrix i_dut (
		.clk(clk), .arst_n(arst_n), .start(start),
		.eye_x(eye_x), .eye_y(eye_y), .eye_z(eye_z),
		.target_x(target_x), .target_y(target_y), .target_z(target_z),
		.hint_up_x(hint_up_x), .hint_up_y(hint_up_y), .hint_up_z(hint_up_z),
		.busy(busy), .done(done),
		.side_x(side_x), .side_y(side_y), .side_z(side_z),
		.true_up_x(true_up_x), .true_up_y(true_up_y), .true_up_z(true_up_z),
		.back_x(back_x), .back_y(back_y), .back_z(back_z),
		.shift_x(shift_x), .shift_y(shift_y), .shift_z(shift_z)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic longint round_q16(longint x);
		longint unsigned m;
		m = x < 0 ? longint'(-x) : longint'(x);
		m = (m + 64'h8000) >> 16;
		return x < 0 ? -longint'(m) : longint'(m);
	endfunction

	function automatic logic [31:0] clip32(longint x);
		if (x > 64'sh7FFF_FFFF)
			return 32'h7FFF_FFFF;
		if (x < -64'sh8000_0000)
			return 32'h8000_0000;
		return x[31:0];
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned res, b;
		res = 0;
		b = 64'h4000_0000_0000_0000;
		while (b > x)
			b >>= 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// unit-length scaling; short vectors pass through
	function automatic void to_unit(inout longint a, inout longint b, inout longint c);
		longint unsigned m[3], mx, s, r, num;
		longint v[3];
		v = '{a, b, c};
		mx = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] = v[i] < 0 ? longint'(-v[i]) : longint'(v[i]);
			if (m[i] > mx)
				mx = m[i];
		end
		if (mx < 8 && m[0] * m[0] + m[1] * m[1] + m[2] * m[2] < 43)
			return;
		while (mx > 64'h8000_0000) begin
			for (int i = 0; i < 3; i++)
				m[i] >>= 1;
			mx >>= 1;
		end
		while (mx < 64'h4000_0000) begin
			for (int i = 0; i < 3; i++)
				m[i] <<= 1;
			mx <<= 1;
		end
		s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
		r = int_sqrt(s);
		if (r == 0)
			return;
		for (int i = 0; i < 3; i++) begin
			num = m[i] << 16;
			num = (2 * num + r) / (2 * r);
			v[i] = v[i] < 0 ? -longint'(num) : longint'(num);
		end
		a = v[0];
		b = v[1];
		c = v[2];
	endfunction

	function automatic view_t predict_view(logic signed [31:0] e[3], logic signed [31:0] t[3],
			logic signed [31:0] h[3]);
		longint ey[3], f[3], hu[3], sd[3], up[3];
		view_t res;
		for (int i = 0; i < 3; i++) begin
			ey[i] = e[i];
			f[i] = longint'(t[i]) - longint'(e[i]);
			hu[i] = h[i];
		end
		to_unit(f[0], f[1], f[2]);
		sd[0] = round_q16(f[1] * hu[2] - f[2] * hu[1]);
		sd[1] = round_q16(f[2] * hu[0] - f[0] * hu[2]);
		sd[2] = round_q16(f[0] * hu[1] - f[1] * hu[0]);
		to_unit(sd[0], sd[1], sd[2]);
		up[0] = round_q16(sd[1] * f[2] - sd[2] * f[1]);
		up[1] = round_q16(sd[2] * f[0] - sd[0] * f[2]);
		up[2] = round_q16(sd[0] * f[1] - sd[1] * f[0]);
		for (int i = 0; i < 3; i++) begin
			res[i] = clip32(sd[i]);
			res[3 + i] = clip32(up[i]);
			res[6 + i] = clip32(-f[i]);
		end
		res[9] = clip32(-round_q16(sd[0] * ey[0] + sd[1] * ey[1] + sd[2] * ey[2]));
		res[10] = clip32(-round_q16(up[0] * ey[0] + up[1] * ey[1] + up[2] * ey[2]));
		res[11] = clip32(round_q16(f[0] * ey[0] + f[1] * ey[1] + f[2] * ey[2]));
		return res;
	endfunction

	task automatic send_setup(logic signed [31:0] e[3], logic signed [31:0] t[3],
			logic signed [31:0] h[3]);
		// each cycle is idle with the given chance
		while ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		eye_x <= e[0];
		eye_y <= e[1];
		eye_z <= e[2];
		target_x <= t[0];
		target_y <= t[1];
		target_z <= t[2];
		hint_up_x <= h[0];
		hint_up_y <= h[1];
		hint_up_z <= h[2];
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_views.push_back(predict_view(e, t, h));
	endtask

	task automatic send_offset(logic signed [31:0] e[3], int dx, int dy, int dz,
			logic signed [31:0] h[3]);
		logic signed [31:0] t[3];
		t = '{e[0] + dx, e[1] + dy, e[2] + dz};
		send_setup(e, t, h);
	endtask

	function automatic logic signed [31:0] rand_word(int kind);
		case (kind)
			0: return $urandom;
			1: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
			default: return $signed($urandom_range(0, 32)) - 16;
		endcase
	endfunction

	task automatic test_directed();
		logic signed [31:0] z[3], up_y[3], mx[3], mn[3], a[3];
		z = '{0, 0, 0};
		up_y = '{0, 32'sh0001_0000, 0};
		mx = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
		mn = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
		a = '{32'sh0003_0000, 32'sh0002_0000, -32'sh0005_0000};
		send_setup(z, z, z);
		send_setup(z, z, up_y);
		send_offset(a, 3, 3, 3, up_y);
		send_offset(a, 4, 3, 3, up_y);
		send_offset(a, 5, 3, 3, up_y);
		send_offset(a, 7, 7, 7, up_y);
		send_offset(a, -1, 0, 0, up_y);
		send_offset(z, 0, 0, -32'sh0001_0000, up_y);
		send_offset(a, 0, 32'sh0004_0000, 0, up_y);
		send_offset(a, 0, 0, 32'sh0001_0000, z);
		send_setup(mn, mx, up_y);
		send_setup(mx, mn, up_y);
		send_setup(mx, mn, mx);
		send_setup(mn, mx, mn);
		send_setup(mx, z, mn);
		send_setup(mn, z, up_y);
		send_offset(mx, -32'sh0001_0000, 0, 0, up_y);
		send_offset(mn, 32'sh0001_0000, 32'sh0002_0000, 0, mx);
		send_offset(z, 32'sh0001_0000, 0, 0, '{32'sh0003_0000, 0, 0});
		send_setup('{-1, -1, -1}, '{1, 1, 1}, '{-1, 1, -1});
	endtask

	task automatic test_random(int count, int idle_pct);
		logic signed [31:0] e[3], t[3], h[3];
		int kind;
		sender_idle_pct = idle_pct;
		repeat (count) begin
			kind = $urandom_range(0, 9);
			for (int i = 0; i < 3; i++) begin
				e[i] = rand_word(kind < 4 ? 0 : 1);
				h[i] = rand_word(kind < 3 ? 0 : 1);
				t[i] = kind < 7 ? rand_word(kind < 2 ? 0 : 1) : e[i] + rand_word(2);
			end
			// up hint along forward
			if (kind == 9)
				for (int i = 0; i < 3; i++)
					h[i] = (t[i] - e[i]) * 3;
			send_setup(e, t, h);
		end
	endtask

	always @(posedge clk) begin
		view_t got, want;
		if (arst_n) begin
			got = {side_x, side_y, side_z, true_up_x, true_up_y, true_up_z,
				back_x, back_y, back_z, shift_x, shift_y, shift_z};
			got = {<<32{got}};
			if ((start && !busy) || done)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (done) begin
				if (pending_views.size() == 0) begin
					errors++;
					$display("%0t: unexpected transaction", $time);
				end else begin
					want = pending_views.pop_front();
					for (int i = 0; i < 12; i++)
						if (got[i] !== want[i]) begin
							errors++;
							$display("%0t: %s expected %h actual %h", $time,
								entry_name[i], want[i], got[i]);
						end
				end
			end
			if (quiet_cycles >= WATCH_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		{eye_x, eye_y, eye_z, target_x, target_y, target_z} = '0;
		{hint_up_x, hint_up_y, hint_up_z} = '0;
		repeat (8)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		sender_idle_pct = 28;
		test_directed();
		test_random(130, 28);
		test_random(130, 72);
		test_random(140, 0);
		start <= 1'b0;
		while (pending_views.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule

// File: files.f
src/lav_pkg.sv
src/lav_norm.sv
src/look_at_view_matrix.sv
tb/look_at_view_matrix_tb.sv
